[hw/rtl/cps_pkg.sv]
// Shared types and constants for the PAM site scanner.
// No dependencies; imported by every module of the block.
package cps_pkg;

	localparam int POS_W    = 32;
	localparam int PS_BITS  = 60;
	localparam int PLEN_W   = 5;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 64;

	// base codes
	localparam logic [2:0] CODE_A = 3'd0;
	localparam logic [2:0] CODE_C = 3'd1;
	localparam logic [2:0] CODE_G = 3'd2;
	localparam logic [2:0] CODE_T = 3'd3;
	localparam logic [2:0] CODE_N = 3'd4;

	localparam logic [7:0] BYTE_LF = 8'd10;

	localparam logic STRAND_FWD = 1'b0;
	localparam logic STRAND_REV = 1'b1;

	// register indexes (byte address 8*index)
	localparam logic [1:0] REG_PAM_LOW  = 2'd0;
	localparam logic [1:0] REG_PAM_HIGH = 2'd1;
	localparam logic [1:0] REG_PAM_LEN  = 2'd2;

	localparam logic [63:0]       PAM_LOW_RST  = 64'd1103;
	localparam logic [15:0]       PAM_HIGH_RST = 16'd0;
	localparam logic [PLEN_W-1:0] PAM_LEN_RST  = 5'd3;

	// one evaluated base that produced at least one hit
	typedef struct packed {
		logic               fwd;
		logic               rev;
		logic [PLEN_W-1:0]  plen;
		logic [POS_W-1:0]   cnt;
		logic [PS_BITS-1:0] fwd_ps;
		logic [PS_BITS-1:0] rev_ps;
	} entry_t;

endpackage

[hw/rtl/crispr_pam_site_scanner.sv]
// PAM site scanner top level: configuration registers and front/queue/back wiring.
// Depends on cps_pkg, cps_front, cps_fifo, cps_back.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one sequence byte per transfer with
//   new_sequence; line feeds are dropped, new_sequence restarts the window and count.
//   Output channel (out_valid/out_ready) gives one hit per transfer: strand, 1-based
//   start_pos/end_pos and the 20-base protospacer; last marks the final hit of a base.
//   Registers on the APB port: 0x00 PAM masks 0-15, 0x08 masks 16-19, 0x10 PAM length.
//   Write them only while no bases are in flight.
// Timing:
//   A base enters every cycle while in_ready is high. Its first hit passes the window
//   register, the queue and the output register; a base that hits both strands gives
//   two results, which is what sets the rate: one result per cycle out of the output register while out_ready is high.
//   A two-entry queue lets the front end run on while a result waits.
// Reset clears the window to N, the count to zero, the queue and the output valid.
// When the receiver stalls the output holds, the queue fills, and in_ready drops
// once a hitting base cannot be queued.
module crispr_pam_site_scanner
	import cps_pkg::*;
#(
	parameter int PROTO_LEN = 20,
	parameter int PAM_MAX   = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         base,
	input  logic               new_sequence,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               strand,
	output logic [POS_W-1:0]   start_pos,
	output logic [POS_W-1:0]   end_pos,
	output logic [PS_BITS-1:0] protospacer,
	output logic               last
);

	logic [63:0]       pam_low_q;
	logic [15:0]       pam_high_q;
	logic [PLEN_W-1:0] pam_len_q;
	logic              wr_en;
	logic [1:0]        reg_idx;

	logic   fifo_full, fifo_not_empty, push, pop;
	entry_t push_data, head;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pam_low_q  <= PAM_LOW_RST;
			pam_high_q <= PAM_HIGH_RST;
			pam_len_q  <= PAM_LEN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAM_LOW:  pam_low_q  <= pwdata;
				REG_PAM_HIGH: pam_high_q <= pwdata[15:0];
				REG_PAM_LEN:  pam_len_q  <= pwdata[PLEN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAM_LOW:  prdata = pam_low_q;
			REG_PAM_HIGH: prdata = {48'd0, pam_high_q};
			REG_PAM_LEN:  prdata = {{(DATA_W-PLEN_W){1'b0}}, pam_len_q};
			default:      prdata = '0;
		endcase
	end

	cps_front #(
		.PROTO_LEN(PROTO_LEN),
		.PAM_MAX  (PAM_MAX)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.base          (base),
		.new_sequence  (new_sequence),
		.pam_codes_low (pam_low_q),
		.pam_codes_high(pam_high_q),
		.pam_length    (pam_len_q),
		.fifo_full     (fifo_full),
		.push          (push),
		.push_data     (push_data)
	);

	cps_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.full     (fifo_full),
		.not_empty(fifo_not_empty),
		.head     (head)
	);

	cps_back #(
		.PROTO_LEN(PROTO_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (fifo_not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.strand     (strand),
		.start_pos  (start_pos),
		.end_pos    (end_pos),
		.protospacer(protospacer),
		.last       (last)
	);

endmodule

[hw/rtl/cps_front.sv]
// Front end: base decode, window shift line, position count and PAM match on both strands.
// Depends on cps_pkg; pushes hit entries into cps_fifo.
module cps_front
	import cps_pkg::*;
#(
	parameter int PROTO_LEN = 20,
	parameter int PAM_MAX   = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        base,
	input  logic              new_sequence,
	input  logic [63:0]       pam_codes_low,
	input  logic [15:0]       pam_codes_high,
	input  logic [PLEN_W-1:0] pam_length,
	input  logic              fifo_full,
	output logic              push,
	output entry_t            push_data
);

	localparam int WIN  = PROTO_LEN + PAM_MAX;
	localparam int PS_W = 3 * PROTO_LEN;
	localparam int PLW  = $clog2(PAM_MAX + 1);

	function automatic logic [2:0] byte_code(input logic [7:0] b);
		logic [7:0] u;
		u = b;
		if (u >= "a" && u <= "z")
			u = u - 8'd32;
		case (u)
			"A":     byte_code = CODE_A;
			"C":     byte_code = CODE_C;
			"G":     byte_code = CODE_G;
			"T":     byte_code = CODE_T;
			default: byte_code = CODE_N;
		endcase
	endfunction

	function automatic logic mask_hits(input logic [3:0] m, input logic [2:0] c);
		if (m == 4'hF)
			mask_hits = 1'b1;
		else if (c >= CODE_N)
			mask_hits = 1'b0;
		else
			mask_hits = m[c[1:0]];
	endfunction

	// A<->T, C<->G is a bit reversal of the mask
	function automatic logic [3:0] comp_mask(input logic [3:0] m);
		comp_mask = {m[0], m[1], m[2], m[3]};
	endfunction

	function automatic logic [2:0] comp_code(input logic [2:0] c);
		comp_code = (c < CODE_N) ? (3'd3 - c) : CODE_N;
	endfunction

	logic [2:0]       win_q [WIN];
	logic [POS_W-1:0] cnt_q;
	logic             valid_s1;

	logic [PLW-1:0]   plen;
	logic [79:0]      pam_vec;
	logic [3:0]       masks [PAM_MAX];
	logic [3:0]       fmask [PAM_MAX];
	logic             fwd_ok, rev_ok, enough, hit_f, hit_r, adv, in_xfer;
	logic [3*WIN-1:0] win_flat;
	logic [PS_W-1:0]  sel, fwd_ps, rev_ps;
	logic [PS_W+PS_BITS-1:0] fwd_ext, rev_ext;

	always_comb begin
		if (pam_length == '0)
			plen = PLW'(1);
		else if (pam_length > PLEN_W'(PAM_MAX))
			plen = PLW'(PAM_MAX);
		else
			plen = pam_length[PLW-1:0];
	end

	assign pam_vec = {pam_codes_high, pam_codes_low};

	// forward pattern position k lines up with window slot plen-1-k
	always_comb begin
		for (int k = 0; k < PAM_MAX; k++)
			masks[k] = pam_vec[4*k +: 4];
		for (int i = 0; i < PAM_MAX; i++) begin
			fmask[i] = 4'hF;
			for (int k = 0; k < PAM_MAX; k++)
				if ((PLW+1)'(k + i + 1) == (PLW+1)'(plen))
					fmask[i] = masks[k];
		end
	end

	always_comb begin
		fwd_ok = 1'b1;
		rev_ok = 1'b1;
		for (int i = 0; i < PAM_MAX; i++) begin
			if (PLW'(i) < plen) begin
				if (!mask_hits(fmask[i], win_q[i]))
					fwd_ok = 1'b0;
				if (!mask_hits(comp_mask(masks[i]), win_q[PROTO_LEN + i]))
					rev_ok = 1'b0;
			end
		end
	end

	assign enough = cnt_q >= (POS_W'(PROTO_LEN) + POS_W'(plen));
	assign hit_f  = valid_s1 && enough && fwd_ok;
	assign hit_r  = valid_s1 && enough && rev_ok;

	always_comb begin
		for (int i = 0; i < WIN; i++)
			win_flat[3*i +: 3] = win_q[i];
		sel = win_flat[3 +: PS_W];
		for (int p = 1; p <= PAM_MAX; p++)
			if (plen == PLW'(p))
				sel = win_flat[3*p +: PS_W];
		for (int j = 0; j < PROTO_LEN; j++) begin
			fwd_ps[3*j +: 3] = sel[3*(PROTO_LEN-1-j) +: 3];
			rev_ps[3*j +: 3] = comp_code(win_q[j]);
		end
	end

	assign fwd_ext = {{PS_BITS{1'b0}}, fwd_ps};
	assign rev_ext = {{PS_BITS{1'b0}}, rev_ps};

	// stage holds while a hit cannot enter the queue
	assign adv      = !valid_s1 || !(hit_f || hit_r) || !fifo_full;
	assign in_ready = adv;
	assign in_xfer  = in_valid && in_ready;
	assign push     = valid_s1 && (hit_f || hit_r) && !fifo_full;

	always_comb begin
		push_data.fwd    = hit_f;
		push_data.rev    = hit_r;
		push_data.plen   = PLEN_W'(plen);
		push_data.cnt    = cnt_q;
		push_data.fwd_ps = fwd_ext[PS_BITS-1:0];
		push_data.rev_ps = rev_ext[PS_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN; i++)
				win_q[i] <= CODE_N;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			if (base == BYTE_LF) begin
				if (new_sequence) begin
					for (int i = 0; i < WIN; i++)
						win_q[i] <= CODE_N;
					cnt_q <= '0;
				end
				valid_s1 <= 1'b0;
			end else begin
				win_q[0] <= byte_code(base);
				for (int i = 1; i < WIN; i++)
					win_q[i] <= new_sequence ? CODE_N : win_q[i-1];
				if (new_sequence)
					cnt_q <= POS_W'(1);
				else if (cnt_q != '1)
					cnt_q <= cnt_q + POS_W'(1);
				valid_s1 <= 1'b1;
			end
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

[hw/rtl/cps_fifo.sv]
// Two-entry queue of hit entries between front and back end.
// Depends on cps_pkg for entry_t.
module cps_fifo
	import cps_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output entry_t head
);

	localparam int DEPTH = 2;

	entry_t     mem_q [DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full      = count_q == 2'(DEPTH);
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/cps_back.sv]
// Back end: expands a queued entry into one or two results and holds the output register.
// Depends on cps_pkg; reads the head of cps_fifo.
module cps_back
	import cps_pkg::*;
#(
	parameter int PROTO_LEN = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  entry_t             head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               strand,
	output logic [POS_W-1:0]   start_pos,
	output logic [POS_W-1:0]   end_pos,
	output logic [PS_BITS-1:0] protospacer,
	output logic               last
);

	logic             out_valid_q, sub_q, load, emit_fwd;
	logic [POS_W-1:0] fwd_end;

	assign load     = head_valid && (!out_valid_q || out_ready);
	// forward result goes first; sub_q marks it as already sent
	assign emit_fwd = head.fwd && !sub_q;
	assign pop      = load && (!emit_fwd || !head.rev);
	assign fwd_end  = head.cnt - POS_W'(head.plen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load)
				sub_q <= emit_fwd && head.rev;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_fwd) begin
				strand      <= STRAND_FWD;
				start_pos   <= fwd_end - POS_W'(PROTO_LEN - 1);
				end_pos     <= fwd_end;
				protospacer <= head.fwd_ps;
				last        <= !head.rev;
			end else begin
				strand      <= STRAND_REV;
				start_pos   <= head.cnt - POS_W'(PROTO_LEN - 1);
				end_pos     <= head.cnt;
				protospacer <= head.rev_ps;
				last        <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/cps_checker.sv]
// Port-level checks for the PAM site scanner, bound to the top level.
// Depends on cps_pkg and crispr_pam_site_scanner.
module cps_checker
	import cps_pkg::*;
#(
	parameter int PROTO_LEN = 20
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               strand,
	input logic [POS_W-1:0]   start_pos,
	input logic [POS_W-1:0]   end_pos,
	input logic [PS_BITS-1:0] protospacer,
	input logic               last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({strand, start_pos, end_pos,
			protospacer, last}))
		else $error("output changed while stalled");

	// a reverse hit is always the final hit of its base
	a_rev_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && strand == STRAND_REV |-> last)
		else $error("reverse hit not marked last");

	// a forward hit not marked last is followed at once by its reverse hit
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && strand == STRAND_FWD && !last |=>
			out_valid && strand == STRAND_REV)
		else $error("reverse hit missing after forward hit");

	// protospacer span is fixed
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_pos - start_pos) == POS_W'(PROTO_LEN - 1))
		else $error("hit span wrong");

endmodule

bind crispr_pam_site_scanner cps_checker #(
	.PROTO_LEN(PROTO_LEN)
) u_cps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.strand     (strand),
	.start_pos  (start_pos),
	.end_pos    (end_pos),
	.protospacer(protospacer),
	.last       (last)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// Testbench for crispr_pam_site_scanner: streams sequence bytes, predicts every hit
// on both strands and checks each result transfer. Depends on cps_pkg and the RTL only.
module tb
	import cps_pkg::*;
();

	localparam int SPACER_LEN = 20;
	localparam int PAM_SLOTS  = 20;
	localparam int WIN_LEN    = SPACER_LEN + PAM_SLOTS;
	localparam int LIMIT      = 400000;

	typedef struct packed {
		logic               strand;
		logic [POS_W-1:0]   first_pos;
		logic [POS_W-1:0]   last_pos;
		logic [PS_BITS-1:0] spacer;
		logic               is_last;
	} hit_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid, in_ready;
	logic [7:0]         base;
	logic               new_sequence;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               strand;
	logic [POS_W-1:0]   start_pos, end_pos;
	logic [PS_BITS-1:0] protospacer;
	logic               last;

	// scanner state as predicted
	logic [2:0]        win [WIN_LEN];
	logic [31:0]       seen_count;
	logic [63:0]       pam_lo;
	logic [15:0]       pam_hi;
	logic [PLEN_W-1:0] pam_len;

	hit_t expected_hits [$];
	int   mismatches = 0;
	int   cycle_count = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_sent = 0;
	logic restart_pending = 1'b0;

	crispr_pam_site_scanner uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .base(base),
		.new_sequence(new_sequence),
		.out_valid(out_valid), .out_ready(out_ready), .strand(strand),
		.start_pos(start_pos), .end_pos(end_pos), .protospacer(protospacer),
		.last(last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 40)
			$display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_hits
		hit_t want;
		if (out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected hit, start_pos", 64'(start_pos), 64'd0);
			end else begin
				want = expected_hits.pop_front();
				if (strand !== want.strand)
					report_mismatch("strand", 64'(strand), 64'(want.strand));
				if (start_pos !== want.first_pos)
					report_mismatch("start_pos", 64'(start_pos), 64'(want.first_pos));
				if (end_pos !== want.last_pos)
					report_mismatch("end_pos", 64'(end_pos), 64'(want.last_pos));
				if (protospacer !== want.spacer)
					report_mismatch("protospacer", 64'(protospacer), 64'(want.spacer));
				if (last !== want.is_last)
					report_mismatch("last", 64'(last), 64'(want.is_last));
			end
		end
	end

	// ---------------- prediction ----------------

	function automatic logic [3:0] mask_at(int k);
		if (k < 16)
			return pam_lo[4*k +: 4];
		return pam_hi[4*(k-16) +: 4];
	endfunction

	// A<->T, C<->G is a bit reversal of the mask
	function automatic logic [3:0] flip_mask(logic [3:0] m);
		return {m[0], m[1], m[2], m[3]};
	endfunction

	function automatic logic mask_covers(logic [3:0] m, logic [2:0] code);
		if (m == 4'hF)
			return 1'b1;
		if (code >= CODE_N)
			return 1'b0;
		return m[code[1:0]];
	endfunction

	function automatic logic [2:0] base_code(logic [7:0] b);
		logic [7:0] u;
		u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
		case (u)
			"A": return CODE_A;
			"C": return CODE_C;
			"G": return CODE_G;
			"T": return CODE_T;
			default: return CODE_N;
		endcase
	endfunction

	function automatic logic [2:0] comp_code(logic [2:0] c);
		return (c < CODE_N) ? 3'd3 - c : CODE_N;
	endfunction

	function automatic int eff_pam_len();
		int p;
		p = pam_len;
		if (p < 1)
			p = 1;
		if (p > PAM_SLOTS)
			p = PAM_SLOTS;
		return p;
	endfunction

	function automatic void clear_window();
		for (int i = 0; i < WIN_LEN; i++)
			win[i] = CODE_N;
	endfunction

	task automatic scan_base(input logic [7:0] b, input logic ns);
		int plen, k, j;
		logic fwd_hit, rev_hit;
		logic [PS_BITS-1:0] sp;
		hit_t h;
		if (ns) begin
			clear_window();
			seen_count = '0;
		end
		if (b == BYTE_LF)
			return;
		for (k = WIN_LEN - 1; k > 0; k--)
			win[k] = win[k-1];
		win[0] = base_code(b);
		if (seen_count != 32'hFFFF_FFFF)
			seen_count++;
		plen = eff_pam_len();
		if (seen_count < SPACER_LEN + plen)
			return;
		fwd_hit = 1'b1;
		rev_hit = 1'b1;
		for (k = 0; k < plen; k++) begin
			if (!mask_covers(mask_at(k), win[plen-1-k]))
				fwd_hit = 1'b0;
			if (!mask_covers(flip_mask(mask_at(plen-1-k)), win[SPACER_LEN+plen-1-k]))
				rev_hit = 1'b0;
		end
		if (fwd_hit) begin
			sp = '0;
			for (j = 0; j < SPACER_LEN; j++)
				sp[3*j +: 3] = win[plen+SPACER_LEN-1-j];
			h.strand    = STRAND_FWD;
			h.first_pos = seen_count - plen - SPACER_LEN + 1;
			h.last_pos  = seen_count - plen;
			h.spacer    = sp;
			h.is_last   = !rev_hit;
			expected_hits.push_back(h);
		end
		if (rev_hit) begin
			sp = '0;
			for (j = 0; j < SPACER_LEN; j++)
				sp[3*j +: 3] = comp_code(win[j]);
			h.strand    = STRAND_REV;
			h.first_pos = seen_count - SPACER_LEN + 1;
			h.last_pos  = seen_count;
			h.spacer    = sp;
			h.is_last   = 1'b1;
			expected_hits.push_back(h);
		end
	endtask

	// ---------------- drivers ----------------

	task automatic send_base(input logic [7:0] b, input logic ns);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		base <= b;
		new_sequence <= ns;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		scan_base(b, ns);
	endtask

	task automatic emit(input logic [7:0] b);
		send_base(b, restart_pending);
		restart_pending = 1'b0;
		items_sent++;
	endtask

	// wait for all hits, then give the pipeline time to finish bases without hits
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PAM_LOW:  pam_lo = value;
			REG_PAM_HIGH: pam_hi = value[15:0];
			REG_PAM_LEN:  pam_len = value[PLEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [63:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 3'b000};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_pam(input logic [63:0] lo, input logic [15:0] hi,
			input logic [PLEN_W-1:0] len);
		apb_write(REG_PAM_LOW, lo);
		apb_write(REG_PAM_HIGH, {48'd0, hi});
		apb_write(REG_PAM_LEN, {59'd0, len});
		check_reg(REG_PAM_LOW, lo);
		check_reg(REG_PAM_HIGH, {48'd0, hi});
		check_reg(REG_PAM_LEN, {59'd0, len});
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic logic [63:0] rand_masks();
		logic [63:0] v;
		for (int i = 0; i < 16; i++)
			v[4*i +: 4] = ($urandom_range(3) == 0) ? 4'hF : 4'($urandom_range(1, 14));
		return v;
	endfunction

	function automatic logic [7:0] letter_byte(logic [1:0] c);
		logic [7:0] b;
		case (c)
			CODE_A[1:0]: b = "A";
			CODE_C[1:0]: b = "C";
			CODE_G[1:0]: b = "G";
			default:     b = "T";
		endcase
		if ($urandom_range(1))
			b = b | 8'h20;
		return b;
	endfunction

	function automatic logic [7:0] random_byte();
		int r;
		r = $urandom_range(99);
		if (r < 88)
			return letter_byte(2'($urandom_range(3)));
		if (r < 96)
			return 8'($urandom_range(255));
		return BYTE_LF;
	endfunction

	function automatic logic [7:0] byte_for_mask(logic [3:0] m);
		logic [1:0] c;
		if (m == 4'd0)
			return letter_byte(2'($urandom_range(3)));
		if (m == 4'hF && $urandom_range(4) == 0)
			return $urandom_range(1) ? 8'("n") : 8'($urandom_range(128, 255));
		do
			c = 2'($urandom_range(3));
		while (!m[c]);
		return letter_byte(c);
	endfunction

	// mix of planted forward sites, planted reverse sites and plain runs/junk
	task automatic scan_random(input int n_items);
		int target, kind, plen, k, n;
		target = items_sent + n_items;
		plen = eff_pam_len();
		while (items_sent < target) begin
			kind = $urandom_range(9);
			if ($urandom_range(19) == 0)
				restart_pending = 1'b1;
			if (kind < 4) begin
				for (k = 0; k < SPACER_LEN; k++)
					emit(random_byte());
				for (k = 0; k < plen; k++)
					emit(byte_for_mask(mask_at(k)));
			end else if (kind < 7) begin
				for (k = 0; k < plen; k++)
					emit(byte_for_mask(flip_mask(mask_at(plen-1-k))));
				for (k = 0; k < SPACER_LEN; k++)
					emit(random_byte());
			end else if (kind < 9) begin
				n = $urandom_range(1, 30);
				for (k = 0; k < n; k++)
					emit(random_byte());
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					emit($urandom_range(3) == 0 ? BYTE_LF : 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic set_idle(input int s, input int r);
		send_idle_pct = s;
		recv_idle_pct = r;
	endtask

	// ---------------- tests ----------------

	task automatic test_reset_values();
		check_reg(REG_PAM_LOW, PAM_LOW_RST);
		check_reg(REG_PAM_HIGH, {48'd0, PAM_HIGH_RST});
		check_reg(REG_PAM_LEN, {59'd0, PAM_LEN_RST});
	endtask

	// NGG: the 23rd base hits both strands (CC.. oldest, ..GG newest), mixed case,
	// odd bytes as N, a line feed inside, then one more forward hit and a restart
	task automatic test_directed_ngg();
		logic [7:0] seq [0:24];
		seq = '{"C", "C", "a", "g", "t", 8'd0, "A", 8'd255, "c", "G", "n", "T", "x",
			BYTE_LF, "a", "c", "g", "t", "A", "C", "G", "t", "g", "G", "G"};
		for (int i = 0; i < 25; i++)
			send_base(seq[i], i == 0);
		send_base(BYTE_LF, 1'b1);
		send_base("A", 1'b0);
		drain();
	endtask

	task automatic test_pam_sweep();
		set_idle(23, 52);
		scan_random(250);
		drain();
		set_pam(rand_masks(), 16'(rand_masks()), 5'd20);
		scan_random(250);
		drain();

		set_idle(52, 23);
		// length 0 behaves as 1
		set_pam(rand_masks(), 16'hFFFF, 5'd0);
		scan_random(250);
		drain();
		// length past the maximum is clamped
		set_pam(rand_masks(), 16'(rand_masks()), 5'd31);
		scan_random(250);
		drain();

		set_idle(0, 0);
		// all-wildcard single-base PAM: every base past the spacer hits both strands
		set_pam(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd1);
		scan_random(200);
		drain();
		// empty masks match nothing
		set_pam(64'd0, 16'd0, 5'd4);
		scan_random(80);
		drain();
		set_pam(rand_masks(), 16'(rand_masks()), 5'($urandom_range(2, 19)));
		scan_random(300);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		base = '0;
		new_sequence = 1'b0;
		pam_lo = PAM_LOW_RST;
		pam_hi = PAM_HIGH_RST;
		pam_len = PAM_LEN_RST;
		clear_window();
		seen_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		set_idle(23, 52);
		test_directed_ngg();
		test_pam_sweep();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
